// ===== src/srgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_pkg: shared types, codes and helpers for the serial RGB controller
// Request and result layouts, event codes, register indexes, the command
// word, hex digit decoding and the three-segment color wheel.
// ----------------------------------------------------------------------------
package srgb_pkg;

    // Line buffer geometry
    localparam int LINE_MAX = 12;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    localparam int IDX_W    = $clog2(LINE_MAX);

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ERASE = CFG_IDX_W'(1);
    localparam logic [7:0] ENTER_RESET = 8'd13;
    localparam logic [7:0] ERASE_RESET = 8'd127;

    // Event codes
    localparam logic [2:0] EV_ECHO   = 3'd0;
    localparam logic [2:0] EV_ERASE  = 3'd1;
    localparam logic [2:0] EV_ACCEPT = 3'd2;
    localparam logic [2:0] EV_REJECT = 3'd3;
    localparam logic [2:0] EV_FRAME  = 3'd4;

    // Request function codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Command words and characters
    localparam int RAINBOW_LEN = 11;
    localparam logic [RAINBOW_LEN-1:0][7:0] RAINBOW_WORD = "FULLRAINBOW";
    localparam int HEX_LEN    = 8;
    localparam int HEX_DIGITS = 6;
    localparam logic [7:0] CHAR_D = "D";
    localparam logic [7:0] CHAR_6 = "6";
    localparam logic [7:0] CHAR_8 = "8";

    // Color wheel segment bounds
    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] LEVEL_MAX  = 8'd255;

    typedef logic [LINE_MAX-1:0][7:0] line_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] echo_byte;
        logic [7:0] led6_red;
        logic [7:0] led6_green;
        logic [7:0] led6_blue;
        logic [7:0] led7_red;
        logic [7:0] led7_green;
        logic [7:0] led7_blue;
        logic [7:0] led8_red;
        logic [7:0] led8_green;
        logic [7:0] led8_blue;
    } result_t;

    // Line check status handed from the checker to the top level
    typedef struct packed {
        logic        is_rainbow;
        logic        hex_ok;
        logic [1:0]  hex_led;
        logic [23:0] colour;
    } check_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "0" && c <= "9")
            v = c - "0";
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            v = c - "a" + 8'd10;
        return v[3:0];
    endfunction

    // Three-segment color wheel, red:green:blue
    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  t;
        logic [23:0] rgb;
        p = ~pos;
        if (p < WHEEL_SEG1)
            q = p;
        else if (p < WHEEL_SEG2)
            q = p - WHEEL_SEG1;
        else
            q = p - WHEEL_SEG2;
        t = 8'({q, 1'b0} + {1'b0, q});
        if (p < WHEEL_SEG1)
            rgb = {LEVEL_MAX - t, 8'd0, t};
        else if (p < WHEEL_SEG2)
            rgb = {8'd0, t, LEVEL_MAX - t};
        else
            rgb = {t, LEVEL_MAX - t, 8'd0};
        return rgb;
    endfunction

endpackage
`default_nettype wire

// ===== src/srgb_line_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_line_check: command line decoder
// Compares the buffered line against the rainbow word and the hex color
// command form in parallel and extracts the target LED and 24-bit color.
// ----------------------------------------------------------------------------
module srgb_line_check (
    input  wire srgb_pkg::line_t             line,
    input  wire logic [srgb_pkg::LEN_W-1:0]  line_len,
    output srgb_pkg::check_t                 check
);
    import srgb_pkg::*;

    logic rainbow_match;
    logic digits_ok;
    logic [23:0] colour;

    // Match the rainbow word character by character
    always_comb
    begin
        rainbow_match = (line_len == LEN_W'(RAINBOW_LEN));
        for (int k = 0; k < RAINBOW_LEN; k++)
        begin
            if (line[k] != RAINBOW_WORD[RAINBOW_LEN-1-k])
                rainbow_match = 1'b0;
        end
    end

    // Decode the six hex digits, first digit most significant
    always_comb
    begin
        digits_ok = 1'b1;
        colour    = '0;
        for (int k = 0; k < HEX_DIGITS; k++)
        begin
            if (!is_hex(line[k]))
                digits_ok = 1'b0;
            colour = {colour[19:0], hex_nibble(line[k])};
        end
    end

    assign check.is_rainbow = rainbow_match;
    assign check.hex_ok     = (line_len == LEN_W'(HEX_LEN)) && digits_ok &&
                              (line[6] == CHAR_D) &&
                              (line[7] >= CHAR_6) && (line[7] <= CHAR_8);
    assign check.hex_led    = 2'(line[7] - CHAR_6);
    assign check.colour     = colour;

endmodule
`default_nettype wire

// ===== src/serial_rgb_command_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_rgb_command_controller: serial command line for three RGB LEDs
// Buffers received characters, decodes rainbow and hex color commands on
// enter, and emits LED frames on wheel ticks.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result register is not held by a stall:
// a request is captured in the item register, decoded against the line buffer
// in one pass and its event is loaded into the result register once that
// register is free or being taken. The two registers let a new request enter
// while a finished result waits. Requests that produce no event (an ordinary
// byte on a full line, an erase on an empty line) update nothing visible and
// pass through without a result. The configuration port is always ready.
// ----------------------------------------------------------------------------
module serial_rgb_command_controller (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire srgb_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output srgb_pkg::result_t                     result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [srgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                       cfg_wdata
);
    import srgb_pkg::*;

    logic              in_vld_reg;
    item_t             in_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    result_t           out_reg;
    result_t           out_next;
    logic              has_result;
    logic              advance;

    logic [7:0]        enter_reg;
    logic [7:0]        erase_reg;
    line_t             line_reg;
    line_t             line_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [2:0][23:0]  colour_reg;
    logic [2:0][23:0]  colour_next;
    logic [2:0]        flags_reg;
    logic [2:0]        flags_next;
    logic [7:0]        wheel_reg;
    logic [7:0]        wheel_next;

    check_t            check;
    logic [LEN_W-1:0]  len_m1;
    logic [23:0]       wheel_now;
    logic [2:0][23:0]  led_rgb;

    srgb_line_check u_check (
        .line     (line_reg),
        .line_len (len_reg),
        .check    (check)
    );

    // Handshake: move the held request on when the result slot frees up
    assign advance    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall = in_vld_reg && !advance;
    assign cfg_ready  = 1'b1;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item_valid && !item_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_reg <= ENTER_RESET;
            erase_reg <= ERASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENTER: enter_reg <= cfg_wdata;
                REG_ERASE: erase_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign len_m1    = len_reg - LEN_W'(1);
    assign wheel_now = wheel_rgb(wheel_reg);

    // Per-LED color for a frame: rainbow or fixed
    always_comb
    begin
        for (int led = 0; led < 3; led++)
            led_rgb[led] = flags_reg[led] ? wheel_now : colour_reg[led];
    end

    // Decode the request and work out next state and event
    always_comb
    begin
        line_next   = line_reg;
        len_next    = len_reg;
        colour_next = colour_reg;
        flags_next  = flags_reg;
        wheel_next  = wheel_reg;
        out_next    = '0;
        has_result  = 1'b0;

        if (in_reg.func == FUNC_TICK)
        begin
            has_result          = 1'b1;
            out_next.event_kind = EV_FRAME;
            out_next.led6_red   = led_rgb[0][23:16];
            out_next.led6_green = led_rgb[0][15:8];
            out_next.led6_blue  = led_rgb[0][7:0];
            out_next.led7_red   = led_rgb[1][23:16];
            out_next.led7_green = led_rgb[1][15:8];
            out_next.led7_blue  = led_rgb[1][7:0];
            out_next.led8_red   = led_rgb[2][23:16];
            out_next.led8_green = led_rgb[2][15:8];
            out_next.led8_blue  = led_rgb[2][7:0];
            wheel_next          = wheel_reg + 8'd1;
        end
        else if (in_reg.rx_byte == enter_reg)
        begin
            has_result          = 1'b1;
            out_next.event_kind = EV_REJECT;
            if (check.is_rainbow)
            begin
                flags_next          = 3'b111;
                out_next.event_kind = EV_ACCEPT;
            end
            else if (check.hex_ok)
            begin
                colour_next[check.hex_led] = check.colour;
                flags_next[check.hex_led]  = 1'b0;
                out_next.event_kind        = EV_ACCEPT;
            end
            line_next = '0;
            len_next  = '0;
        end
        else if (in_reg.rx_byte == erase_reg)
        begin
            if (len_reg != '0)
            begin
                has_result                  = 1'b1;
                out_next.event_kind         = EV_ERASE;
                line_next[len_m1[IDX_W-1:0]] = 8'd0;
                len_next                    = len_m1;
            end
        end
        else if (len_reg < LEN_W'(LINE_MAX))
        begin
            has_result                    = 1'b1;
            out_next.event_kind           = EV_ECHO;
            out_next.echo_byte            = in_reg.rx_byte;
            line_next[len_reg[IDX_W-1:0]] = in_reg.rx_byte;
            len_next                      = len_reg + LEN_W'(1);
        end
    end

    // Commit state when the request moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            len_reg    <= '0;
            colour_reg <= '0;
            flags_reg  <= '0;
            wheel_reg  <= '0;
        end
        else if (advance)
        begin
            line_reg   <= line_next;
            len_reg    <= len_next;
            colour_reg <= colour_next;
            flags_reg  <= flags_next;
            wheel_reg  <= wheel_next;
        end
    end

    // Result register: load on a new event, drop once taken
    always_comb
    begin
        if (advance)
            out_vld_next = has_result;
        else if (!result_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_reg <= out_next;
    end

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_MAX))
        else $error("line length beyond buffer size");

    a_tick_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.func == FUNC_TICK |=> wheel_reg == $past(wheel_reg) + 8'd1)
        else $error("wheel position did not step on a tick");

    a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.func == FUNC_BYTE && in_reg.rx_byte == enter_reg
        |=> len_reg == '0 && out_vld_reg &&
            (out_reg.event_kind == EV_ACCEPT || out_reg.event_kind == EV_REJECT))
        else $error("enter did not clear the line or report a verdict");

    a_rainbow_sets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.func == FUNC_BYTE && in_reg.rx_byte == enter_reg &&
        check.is_rainbow |=> flags_reg == 3'b111)
        else $error("rainbow command did not set all LEDs");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_vld_reg && out_vld_reg && result_stall)
        else $error("request stalled with room in the result register");

endmodule
`default_nettype wire

// ===== tb/serial_rgb_command_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rgb_command_checker: request/result scoreboard for the RGB controller
// Watches the request, result and register channels, keeps its own copy of
// the line buffer, LED colors, rainbow flags and wheel position, predicts the
// event each accepted request raises and checks results in order.
// ----------------------------------------------------------------------------
module serial_rgb_command_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire logic                           item_valid,
    input  wire logic                           item_stall,
    input  wire srgb_pkg::item_t                item,
    input  wire logic                           result_valid,
    input  wire logic                           result_stall,
    input  wire srgb_pkg::result_t              result,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [srgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_wdata,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import srgb_pkg::*;

    // Shadow of the controller state
    logic [7:0]  enter_code;
    logic [7:0]  erase_code;
    logic [7:0]  line_chars [LINE_MAX];
    int          line_len;
    logic [23:0] fixed_rgb [3];
    logic [2:0]  rainbow_on;
    logic [7:0]  wheel_pos;

    result_t     expected_events [$];
    int          errors = 0;

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    // Work out the event one request raises and update the shadow state
    task automatic advance_controller(input item_t req);
        result_t     ev;
        logic [7:0]  c;
        logic [23:0] colour;
        logic [23:0] wheel;
        logic [23:0] shown [3];
        bit          rainbow_match;
        bit          hex_match;
        int          nib;
        int          spin;
        int          led;
        int          k;
        ev = '0;
        if (req.func == FUNC_TICK)
        begin
            // three-segment wheel at the running position
            spin = 255 - int'(wheel_pos);
            if (spin < 85)
                wheel = {8'(255 - 3 * spin), 8'd0, 8'(3 * spin)};
            else if (spin < 170)
            begin
                spin -= 85;
                wheel = {8'd0, 8'(3 * spin), 8'(255 - 3 * spin)};
            end
            else
            begin
                spin -= 170;
                wheel = {8'(3 * spin), 8'(255 - 3 * spin), 8'd0};
            end
            for (k = 0; k < 3; k++)
                shown[k] = rainbow_on[k] ? wheel : fixed_rgb[k];
            ev.event_kind = EV_FRAME;
            {ev.led6_red, ev.led6_green, ev.led6_blue} = shown[0];
            {ev.led7_red, ev.led7_green, ev.led7_blue} = shown[1];
            {ev.led8_red, ev.led8_green, ev.led8_blue} = shown[2];
            wheel_pos = wheel_pos + 8'd1;
            expected_events.push_back(ev);
        end
        else if (req.rx_byte == enter_code)
        begin
            // judge the line, then clear it
            rainbow_match = (line_len == RAINBOW_LEN);
            for (k = 0; k < RAINBOW_LEN; k++)
                if (line_chars[k] != RAINBOW_WORD[RAINBOW_LEN - 1 - k])
                    rainbow_match = 0;
            hex_match = (line_len == HEX_LEN) && (line_chars[6] == "D") &&
                        (line_chars[7] >= "6") && (line_chars[7] <= "8");
            colour = '0;
            for (k = 0; k < HEX_DIGITS; k++)
            begin
                c = line_chars[k];
                nib = 0;
                if (c >= "0" && c <= "9")
                    nib = c - "0";
                else if (c >= "A" && c <= "F")
                    nib = c - "A" + 10;
                else if (c >= "a" && c <= "f")
                    nib = c - "a" + 10;
                else
                    hex_match = 0;
                colour = {colour[19:0], 4'(nib)};
            end
            if (rainbow_match)
            begin
                rainbow_on = 3'b111;
                ev.event_kind = EV_ACCEPT;
            end
            else if (hex_match)
            begin
                led = line_chars[7] - "6";
                fixed_rgb[led] = colour;
                rainbow_on[led] = 1'b0;
                ev.event_kind = EV_ACCEPT;
            end
            else
                ev.event_kind = EV_REJECT;
            for (k = 0; k < LINE_MAX; k++)
                line_chars[k] = '0;
            line_len = 0;
            expected_events.push_back(ev);
        end
        else if (req.rx_byte == erase_code)
        begin
            // drop the last character; an empty line stays silent
            if (line_len != 0)
            begin
                line_len--;
                line_chars[line_len] = '0;
                ev.event_kind = EV_ERASE;
                expected_events.push_back(ev);
            end
        end
        else if (line_len < LINE_MAX)
        begin
            // hold the character and echo it; a full line drops it silently
            line_chars[line_len] = req.rx_byte;
            line_len++;
            ev.event_kind = EV_ECHO;
            ev.echo_byte = req.rx_byte;
            expected_events.push_back(ev);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            enter_code = ENTER_RESET;
            erase_code = ERASE_RESET;
            for (int k = 0; k < LINE_MAX; k++)
                line_chars[k] = '0;
            line_len = 0;
            for (int k = 0; k < 3; k++)
                fixed_rgb[k] = '0;
            rainbow_on = '0;
            wheel_pos = '0;
            expected_events.delete();
            pending_count <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            // retire the result first so a request taken at this edge cannot match it
            if (result_valid && !result_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result with no request outstanding: kind %0d",
                           result.event_kind);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.event_kind, result.event_kind);
                    compare_field("echo_byte", want.echo_byte, result.echo_byte);
                    compare_field("led6_red", want.led6_red, result.led6_red);
                    compare_field("led6_green", want.led6_green, result.led6_green);
                    compare_field("led6_blue", want.led6_blue, result.led6_blue);
                    compare_field("led7_red", want.led7_red, result.led7_red);
                    compare_field("led7_green", want.led7_green, result.led7_green);
                    compare_field("led7_blue", want.led7_blue, result.led7_blue);
                    compare_field("led8_red", want.led8_red, result.led8_red);
                    compare_field("led8_green", want.led8_green, result.led8_green);
                    compare_field("led8_blue", want.led8_blue, result.led8_blue);
                end
            end
            // track register writes; unknown indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENTER)
                    enter_code = cfg_wdata;
                else if (cfg_index == REG_ERASE)
                    erase_code = cfg_wdata;
            end
            if (item_valid && !item_stall)
                advance_controller(item);
            pending_count <= expected_events.size();
            mismatch_count <= errors;
        end
    end

endmodule

// ===== tb/tb_serial_rgb_command_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_rgb_command_controller: stimulus and verdict for the RGB controller
// Types directed and random command lines (hex colors, rainbow, noise, erase
// and ticks) under several enter/erase settings with random stalls on both
// channels; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_serial_rgb_command_controller;
    import srgb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;
    int                   mismatch_count;
    int                   pending_count;

    bit                   idle_enable = 1'b1;
    int                   stall_left = 0;
    int                   requests_sent = 0;
    logic [7:0]           enter_now = ENTER_RESET;
    logic [7:0]           erase_now = ERASE_RESET;

    serial_rgb_command_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    serial_rgb_command_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_stall <= (stall_left > 1);
            stall_left <= stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 6) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(1, 5);
        end
        else
            result_stall <= 1'b0;
    end

    // Present one request and hold it until it is taken
    task automatic send_request(input logic func, input logic [7:0] data);
        item_t req;
        req.func = func;
        req.rx_byte = data;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        int waited;
        item_valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; waited < 20000 && pending_count != 0; waited++)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (index == REG_ENTER)
            enter_now = data;
        else if (index == REG_ERASE)
            erase_now = data;
    endtask

    // Set both codes on an idle block, plus a write to an unused index
    task automatic configure(input logic [7:0] enter_val, input logic [7:0] erase_val,
                             input logic [CFG_IDX_W-1:0] spare_index);
        settle();
        write_one(REG_ENTER, enter_val);
        write_one(REG_ERASE, erase_val);
        write_one(spare_index, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10)
            return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    endfunction

    // Type a line, optionally with stray ticks and typo-then-erase pairs, then enter
    task automatic type_line(input logic [7:0] chars[$], input bit noisy);
        logic [7:0] junk;
        foreach (chars[k])
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_request(FUNC_TICK, 8'($urandom));
            if (noisy && enter_now != erase_now && $urandom_range(0, 11) == 0)
            begin
                junk = 8'($urandom);
                if (junk != enter_now && junk != erase_now)
                begin
                    send_request(FUNC_BYTE, junk);
                    send_request(FUNC_BYTE, erase_now);
                end
            end
            send_request(FUNC_BYTE, chars[k]);
        end
        send_request(FUNC_BYTE, enter_now);
    endtask

    task automatic hex_command();
        logic [7:0] chars[$];
        int         spot;
        for (int k = 0; k < HEX_DIGITS; k++)
            chars.push_back(random_hex_char());
        chars.push_back("D");
        chars.push_back(8'("6" + $urandom_range(0, 2)));
        // break about one command in five
        if ($urandom_range(0, 4) == 0)
        begin
            spot = $urandom_range(0, HEX_LEN - 1);
            case ($urandom_range(0, 4))
                0: chars[spot] = 8'($urandom);
                1: chars[7] = $urandom_range(0, 1) ? "5" : "9";
                2: chars[6] = "d";
                3: chars.delete(spot);
                default: chars.insert(spot, random_hex_char());
            endcase
        end
        type_line(chars, 1'b1);
    endtask

    task automatic rainbow_command();
        logic [7:0] chars[$];
        int         spot;
        for (int k = RAINBOW_LEN - 1; k >= 0; k--)
            chars.push_back(RAINBOW_WORD[k]);
        if ($urandom_range(0, 3) == 0)
        begin
            spot = $urandom_range(0, RAINBOW_LEN - 1);
            case ($urandom_range(0, 3))
                0: chars[spot] = 8'($urandom);
                1: chars[spot] = chars[spot] | 8'h20;
                2: chars.delete(spot);
                default: chars.push_back(8'($urandom_range(65, 90)));
            endcase
        end
        type_line(chars, 1'b1);
    endtask

    // Random bytes of any value, long enough at times to overrun the line
    task automatic noise_line();
        logic [7:0] chars[$];
        repeat ($urandom_range(0, LINE_MAX + 4))
            chars.push_back(8'($urandom));
        type_line(chars, 1'b1);
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: hex_command();
                4, 5:       rainbow_command();
                6, 7:       noise_line();
                default:
                    repeat ($urandom_range(1, 4))
                        send_request(FUNC_TICK, 8'($urandom));
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] chars[$];
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dark frame, erase on an empty line, mixed-case hex color
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_BYTE, ERASE_RESET);
        chars = '{"a", "B", "c", "D", "e", "F", "D", "7"};
        type_line(chars, 1'b0);
        send_request(FUNC_TICK, 8'hFF);
        // rainbow on all LEDs, then a line with zero and all-ones bytes
        chars.delete();
        for (int k = RAINBOW_LEN - 1; k >= 0; k--)
            chars.push_back(RAINBOW_WORD[k]);
        type_line(chars, 1'b0);
        send_request(FUNC_TICK, 8'h5A);
        chars = '{8'h00, 8'hFF};
        type_line(chars, 1'b0);

        // Random lines under several code settings, extremes and a shared code
        configure(8'd0, 8'd255, CFG_IDX_W'(2));
        run_phase(200);
        configure(8'd255, 8'd0, CFG_IDX_W'(255));
        run_phase(200);
        configure(8'd8, 8'd8, CFG_IDX_W'(128));
        run_phase(150);
        configure(8'd10, 8'd8, CFG_IDX_W'($urandom_range(2, 255)));
        run_phase(200);
        configure(ENTER_RESET, ERASE_RESET, CFG_IDX_W'($urandom_range(2, 255)));
        run_phase(150);
        idle_enable = 1'b0;
        run_phase(150);

        settle();
        repeat (8) @(posedge clk);
        if (pending_count != 0)
            $error("%0d expected results never arrived", pending_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/srgb_pkg.sv
src/srgb_line_check.sv
src/serial_rgb_command_controller.sv
tb/serial_rgb_command_checker.sv
tb/tb_serial_rgb_command_controller.sv
